// ----- sv/sos_pkg.sv -----
// shared constants, types and helpers for the spiral order scan block
package sos_pkg;

	localparam int MAX_ROWS    = 8;
	localparam int MAX_COLS    = 8;
	localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);
	localparam int NUM_BANKS   = 2;
	localparam int RAM_DEPTH   = STORE_DEPTH * NUM_BANKS;
	localparam int RAM_AW      = $clog2(RAM_DEPTH);
	localparam int DATA_W      = 32;
	localparam int DIM_W       = 4;
	localparam int ROW_W       = $clog2(MAX_ROWS);
	localparam int COL_W       = $clog2(MAX_COLS);
	localparam int WALK_IDX_W  = ROW_W + DIM_W;
	localparam int RING_W      = 2;
	localparam int CNT_W       = 7;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 4;
	localparam int JOBQ_DEPTH  = 2;
	localparam int JOBQ_AW     = $clog2(JOBQ_DEPTH);
	localparam int JOBQ_CW     = $clog2(JOBQ_DEPTH + 1);

	localparam logic [DIM_W-1:0] MAX_ROWS_D = DIM_W'(MAX_ROWS);
	localparam logic [DIM_W-1:0] MAX_COLS_D = DIM_W'(MAX_COLS);
	localparam logic [CNT_W-1:0] STORE_DEPTH_C = CNT_W'(STORE_DEPTH);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_COUNT = 1'b0,
		REG_COL_COUNT = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		DIR_RIGHT = 2'd0,
		DIR_DOWN  = 2'd1,
		DIR_LEFT  = 2'd2,
		DIR_UP    = 2'd3
	} dir_t;

	typedef struct packed {
		logic             bank;
		logic [DIM_W-1:0] rows;
		logic [DIM_W-1:0] cols;
		logic [CNT_W-1:0] total;
	} job_t;

	typedef struct packed {
		logic              en;
		logic [RAM_AW-1:0] addr;
		logic [DATA_W-1:0] data;
	} ram_wr_t;

	typedef struct packed {
		logic              en;
		logic [RAM_AW-1:0] addr;
	} ram_rd_t;

	// zero is taken as one, anything past the maximum as the maximum
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] maxv);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > maxv) begin
			r = maxv;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ----- sv/sos_if.sv -----
// handshake channels: element input, spiral output, configuration write
interface sos_in_if;
	import sos_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] element;
	modport source(output valid, output element, input ready);
	modport sink(input valid, input element, output ready);
endinterface

interface sos_out_if;
	import sos_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] spiral_element;
	logic                     final_res;
	modport source(output valid, output spiral_element, output final_res, input ready);
	modport sink(input valid, input spiral_element, input final_res, output ready);
endinterface

interface sos_cfg_if;
	import sos_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ----- sv/sos_ram.sv -----
// generic simple dual-port ram with registered read
module sos_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- sv/sos_front.sv -----
// load side: config registers, row-major element store writes, replay job issue
module sos_front (
	input  logic           clk,
	input  logic           arst_n,
	sos_cfg_if.sink        cfg,
	sos_in_if.sink         elem,
	input  logic           job_full,
	output logic           job_push,
	output sos_pkg::job_t  job,
	output sos_pkg::ram_wr_t ram_wr
);
	import sos_pkg::*;

	logic [DIM_W-1:0]   row_count_q;
	logic [DIM_W-1:0]   col_count_q;
	logic [CNT_W-1:0]   load_q;
	logic               bank_q;
	logic [DIM_W-1:0]   rows_eff;
	logic [DIM_W-1:0]   cols_eff;
	logic [2*DIM_W-1:0] area;
	logic [CNT_W-1:0]   total;
	logic [CNT_W-1:0]   load_inc;
	logic               accept;
	logic               done;

	assign cfg.ready  = 1'b1;
	assign elem.ready = !job_full;
	assign accept     = elem.valid && elem.ready;

	always_comb begin
		rows_eff = eff_dim(row_count_q, MAX_ROWS_D);
		cols_eff = eff_dim(col_count_q, MAX_COLS_D);
		area     = (2*DIM_W)'(rows_eff) * (2*DIM_W)'(cols_eff);
		total    = area[CNT_W-1:0];
		load_inc = load_q + CNT_W'(1);
		done     = load_inc >= total;
	end

	always_comb begin
		ram_wr.en   = accept && (load_q < STORE_DEPTH_C);
		ram_wr.addr = {bank_q, load_q[STORE_AW-1:0]};
		ram_wr.data = elem.element;
		job_push    = accept && done;
		job.bank    = bank_q;
		job.rows    = rows_eff;
		job.cols    = cols_eff;
		job.total   = total;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= MAX_ROWS_D;
			col_count_q <= MAX_COLS_D;
			load_q      <= '0;
			bank_q      <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				unique case (cfg_reg_t'(cfg.index))
					REG_ROW_COUNT: row_count_q <= cfg.data;
					REG_COL_COUNT: col_count_q <= cfg.data;
				endcase
			end
			if (accept) begin
				// a finished matrix moves on to the other bank
				if (done) begin
					load_q <= '0;
					bank_q <= ~bank_q;
				end else begin
					load_q <= load_inc;
				end
			end
		end
	end

endmodule

// ----- sv/sos_job_fifo.sv -----
// two-entry queue of replay jobs between the load and replay sides
module sos_job_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sos_pkg::job_t push_job,
	output logic          full,
	output logic          head_valid,
	output sos_pkg::job_t head,
	input  logic          pop
);
	import sos_pkg::*;

	job_t               entry_q [JOBQ_DEPTH];
	logic [JOBQ_AW-1:0] wr_ptr_q;
	logic [JOBQ_AW-1:0] rd_ptr_q;
	logic [JOBQ_CW-1:0] cnt_q;

	assign full       = cnt_q == JOBQ_CW'(JOBQ_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + JOBQ_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + JOBQ_AW'(1);
			end
			cnt_q <= cnt_q + JOBQ_CW'(push) - JOBQ_CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// ----- sv/sos_back.sv -----
// replay side: spiral walker, store reads and two-beat output buffer
module sos_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             job_valid,
	input  sos_pkg::job_t    job,
	output logic             job_pop,
	output sos_pkg::ram_rd_t ram_rd,
	input  logic [sos_pkg::DATA_W-1:0] rd_data,
	sos_out_if.source        spiral
);
	import sos_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WALK = 2'b10
	} walk_state_t;

	walk_state_t       state_q;
	logic              bank_q;
	logic [DIM_W-1:0]  rows_q;
	logic [DIM_W-1:0]  cols_q;
	logic [CNT_W-1:0]  total_q;
	logic [ROW_W-1:0]  walk_row_q;
	logic [COL_W-1:0]  walk_col_q;
	dir_t              dir_q;
	logic [RING_W-1:0] ring_q;
	logic [CNT_W-1:0]  emit_q;

	logic              rd_vld_s1;
	logic              final_s1;
	logic              zero_s1;

	logic [DATA_W-1:0] obuf_data_q  [2];
	logic              obuf_final_q [2];
	logic              obuf_wr_q;
	logic              obuf_rd_q;
	logic [1:0]        ocnt_q;

	logic              pop_out;
	logic [1:0]        occ_next;
	logic              issue;
	logic              last;
	logic              col_oob;
	logic [WALK_IDX_W-1:0] idx;
	logic [ROW_W-1:0]  row_nx;
	logic [COL_W-1:0]  col_nx;
	dir_t              dir_nx;
	logic [RING_W-1:0] ring_nx;

	assign pop_out  = spiral.valid && spiral.ready;
	// beats held plus the one in flight from the ram, after this cycle's drain
	assign occ_next = ocnt_q + 2'(rd_vld_s1) - 2'(pop_out);
	assign issue    = (state_q == ST_WALK) && (occ_next < 2'd2);
	assign last     = (emit_q + CNT_W'(1)) == total_q;
	assign job_pop  = issue && last;

	always_comb begin
		idx         = WALK_IDX_W'(walk_row_q) * WALK_IDX_W'(cols_q)
			+ WALK_IDX_W'(walk_col_q);
		col_oob     = DIM_W'(walk_col_q) >= cols_q;
		ram_rd.en   = issue;
		ram_rd.addr = {bank_q, idx[STORE_AW-1:0]};
	end

	// one step along the ring, turning at its edges
	always_comb begin
		row_nx  = walk_row_q;
		col_nx  = walk_col_q;
		dir_nx  = dir_q;
		ring_nx = ring_q;
		unique case (dir_q)
			DIR_RIGHT: begin
				if (DIM_W'(walk_col_q) + DIM_W'(1) + DIM_W'(ring_q) == cols_q) begin
					dir_nx = DIR_DOWN;
					row_nx = walk_row_q + ROW_W'(1);
				end else begin
					col_nx = walk_col_q + COL_W'(1);
				end
			end
			DIR_DOWN: begin
				if (DIM_W'(walk_row_q) + DIM_W'(1) + DIM_W'(ring_q) == rows_q) begin
					dir_nx = DIR_LEFT;
					col_nx = walk_col_q - COL_W'(1);
				end else begin
					row_nx = walk_row_q + ROW_W'(1);
				end
			end
			DIR_LEFT: begin
				if (walk_col_q == COL_W'(ring_q)) begin
					ring_nx = ring_q + RING_W'(1);
					dir_nx  = DIR_UP;
					row_nx  = walk_row_q - ROW_W'(1);
				end else begin
					col_nx = walk_col_q - COL_W'(1);
				end
			end
			DIR_UP: begin
				if (walk_row_q == ROW_W'(ring_q)) begin
					dir_nx = DIR_RIGHT;
					col_nx = walk_col_q + COL_W'(1);
				end else begin
					row_nx = walk_row_q - ROW_W'(1);
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			walk_row_q <= '0;
			walk_col_q <= '0;
			dir_q      <= DIR_RIGHT;
			ring_q     <= '0;
			emit_q     <= '0;
			rd_vld_s1  <= 1'b0;
			obuf_wr_q  <= 1'b0;
			obuf_rd_q  <= 1'b0;
			ocnt_q     <= '0;
		end else begin
			rd_vld_s1 <= issue;
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						state_q    <= ST_WALK;
						walk_row_q <= '0;
						walk_col_q <= '0;
						dir_q      <= DIR_RIGHT;
						ring_q     <= '0;
						emit_q     <= '0;
					end
				end
				ST_WALK: begin
					if (issue) begin
						walk_row_q <= row_nx;
						walk_col_q <= col_nx;
						dir_q      <= dir_nx;
						ring_q     <= ring_nx;
						emit_q     <= emit_q + CNT_W'(1);
						if (last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (rd_vld_s1) begin
				obuf_wr_q <= ~obuf_wr_q;
			end
			if (pop_out) begin
				obuf_rd_q <= ~obuf_rd_q;
			end
			ocnt_q <= ocnt_q + 2'(rd_vld_s1) - 2'(pop_out);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && job_valid) begin
			bank_q  <= job.bank;
			rows_q  <= job.rows;
			cols_q  <= job.cols;
			total_q <= job.total;
		end
		if (issue) begin
			final_s1 <= last;
			zero_s1  <= col_oob;
		end
		if (rd_vld_s1) begin
			obuf_data_q[obuf_wr_q]  <= zero_s1 ? '0 : rd_data;
			obuf_final_q[obuf_wr_q] <= final_s1;
		end
	end

	assign spiral.valid          = ocnt_q != '0;
	assign spiral.spiral_element = $signed(obuf_data_q[obuf_rd_q]);
	assign spiral.final_res      = obuf_final_q[obuf_rd_q];

endmodule

// ----- sv/spiral_order_scan_core.sv -----
// top level of the spiral order scan block
//
// elem takes one matrix element per beat in row-major order; once
// row_count * col_count elements are in, spiral gives the whole matrix back
// in clockwise spiral order, one beat per element, final_res set on the last.
// cfg writes row_count (index 0) and col_count (index 1); zero counts as one,
// values past eight count as eight. write it only while the block is idle.
// loading takes one cycle per element. the store has two banks, so the next
// matrix loads while the previous one replays; the job queue holds two
// matrices and elem stalls while both banks wait for replay.
// the beat that completes a matrix queues a replay job; the walker then leaves
// idle, issues store reads, and the registered data goes to spiral through the
// output buffer, one beat per cycle while spiral is ready, set by the single
// ram read port. the walker passes through idle between two replays.
// reset leaves an 8 x 8 size, clears the load count, the job queue and the
// walker; the store is not cleared and is never read before it is written.
// when spiral stalls, a two-beat output buffer holds results and the walker
// pauses; no beat is lost.
module spiral_order_scan_core (
	input  logic      clk,
	input  logic      arst_n,
	sos_cfg_if.sink   cfg,
	sos_in_if.sink    elem,
	sos_out_if.source spiral
);
	import sos_pkg::*;

	logic              job_push;
	job_t              job_in;
	logic              job_full;
	logic              job_valid;
	job_t              job_head;
	logic              job_pop;
	ram_wr_t           ram_wr;
	ram_rd_t           ram_rd;
	logic [DATA_W-1:0] rd_data;

	sos_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.elem     (elem),
		.job_full (job_full),
		.job_push (job_push),
		.job      (job_in),
		.ram_wr   (ram_wr)
	);

	sos_job_fifo u_job_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (job_push),
		.push_job   (job_in),
		.full       (job_full),
		.head_valid (job_valid),
		.head       (job_head),
		.pop        (job_pop)
	);

	sos_ram #(
		.WIDTH (DATA_W),
		.DEPTH (RAM_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_wr.en),
		.wr_addr (ram_wr.addr),
		.wr_data (ram_wr.data),
		.rd_en   (ram_rd.en),
		.rd_addr (ram_rd.addr),
		.rd_data (rd_data)
	);

	sos_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job_head),
		.job_pop   (job_pop),
		.ram_rd    (ram_rd),
		.rd_data   (rd_data),
		.spiral    (spiral)
	);

	// loading and replay never touch the same bank
	a_bank_split: assert property (@(posedge clk) disable iff (!arst_n)
		ram_wr.en && ram_rd.en |-> ram_wr.addr[RAM_AW-1] != ram_rd.addr[RAM_AW-1])
		else $error("load and replay collide on one store bank");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !job_full)
		else $error("replay job pushed into a full queue");

	a_read_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		ram_rd.en |-> job_valid)
		else $error("store read with no replay job queued");

	// a completed job frees its slot, so a stalled load resumes next cycle
	a_pop_frees: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop && !job_push |=> !job_full)
		else $error("job queue still full after a pop");

endmodule
